>>> rtl/core/pds_pkg.sv
// Package: shared types, codes and defaults for the periodic deadline scheduler.
package pds_pkg;

	localparam int SLOT_COUNT_DEF = 16;

	typedef enum logic {
		OP_SCHEDULE = 1'b0,
		OP_TICK     = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_ONESHOT = 2'd0,
		MODE_RATE    = 2'd1,
		MODE_DELAY   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		RK_ACCEPT   = 2'd0,
		RK_REJECT   = 2'd1,
		RK_FIRED    = 2'd2,
		RK_TICKDONE = 2'd3
	} rkind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN
	} state_t;

	// Broadcast from the controller to every slot cell.
	typedef struct packed {
		logic        prep;
		logic        fire;
		logic        wr;
		logic        sched;
		logic [7:0]  tag;
		logic [23:0] delay;
		logic [23:0] period;
		logic [1:0]  kind;
	} pds_cmd_t;

	// Candidate handed from cell to cell.
	typedef struct packed {
		logic        vld;
		logic [31:0] age;
		logic [7:0]  tag;
	} pds_tok_t;

	// Per-slot status back to the controller.
	typedef struct packed {
		logic busy;
		logic pending;
	} pds_stat_t;

endpackage

>>> rtl/core/pds_req_if.sv
// Interface: request channel carrying schedule and tick transactions.
interface pds_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  task_tag;
	logic [23:0] first_delay;
	logic [23:0] repeat_interval;
	logic [1:0]  task_mode;

	modport source (output valid, operation, task_tag, first_delay, repeat_interval, task_mode,
		input ready);
	modport sink (input valid, operation, task_tag, first_delay, repeat_interval, task_mode,
		output ready);
endinterface

>>> rtl/core/pds_rsp_if.sv
// Interface: response channel carrying result transactions.
interface pds_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] fired_tag;
	logic [3:0] slot_index;
	logic       last_result;

	modport source (output valid, result_kind, fired_tag, slot_index, last_result, input ready);
	modport sink (input valid, result_kind, fired_tag, slot_index, last_result, output ready);
endinterface

>>> rtl/core/pds_cell.sv
// Slot cell: one timer slot plus one stage of the candidate chain.
module pds_cell import pds_pkg::*; #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pds_cmd_t        cmd,
	input  logic [IW-1:0]   cmd_idx,
	input  logic [31:0]     now,
	input  pds_tok_t        tok_in,
	input  logic [IW-1:0]   tok_in_idx,
	output pds_tok_t        tok_out,
	output logic [IW-1:0]   tok_out_idx,
	output pds_stat_t       stat
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic          busy_q, pend_q;
	logic [31:0]   deadline_q, age_q;
	logic [23:0]   period_q;
	logic [1:0]    kind_q;
	logic [7:0]    tag_q;
	pds_tok_t      tok_q;
	logic [IW-1:0] tok_idx_q;

	logic          sel, claim;
	logic [31:0]   age_next, step;

	assign sel      = (cmd_idx == MY_IDX);
	assign age_next = now - deadline_q;
	assign step     = (period_q == '0) ? 32'd1 : {8'b0, period_q};

	// schedule pass: first free slot wins; tick pass: oldest pending wins, ties to lower slot
	assign claim = cmd.sched ? (!busy_q && !tok_in.vld)
	                         : (pend_q && (!tok_in.vld || (age_q > tok_in.age)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			tok_q  <= '0;
		end else begin
			if (cmd.wr && sel) begin
				busy_q <= 1'b1;
			end else if (cmd.fire && sel) begin
				pend_q <= 1'b0;
				if (kind_q != MODE_RATE && kind_q != MODE_DELAY) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.prep) begin
				pend_q <= busy_q && !age_next[31];
			end
			tok_q <= claim ? pds_tok_t'{vld: 1'b1, age: age_q, tag: tag_q} : tok_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_idx_q <= claim ? MY_IDX : tok_in_idx;
		if (cmd.prep) begin
			age_q <= age_next;
		end
		if (cmd.wr && sel) begin
			deadline_q <= now + {8'b0, cmd.delay};
			period_q   <= cmd.period;
			kind_q     <= cmd.kind;
			tag_q      <= cmd.tag;
		end else if (cmd.fire && sel) begin
			if (kind_q == MODE_RATE) begin
				deadline_q <= deadline_q + step;
			end else if (kind_q == MODE_DELAY) begin
				deadline_q <= now + step;
			end
		end
	end

	assign tok_out     = tok_q;
	assign tok_out_idx = tok_idx_q;
	assign stat        = '{busy: busy_q, pending: pend_q};

endmodule

>>> rtl/core/periodic_deadline_scheduler_core.sv
// Top level: periodic deadline scheduler, a chain of slot cells and a sequencing controller.
// Schedule: the result follows one pass of the candidate down the cell chain.
// Tick: a prep state captures ages, then F+1 passes of the cell chain for F fired tasks.
// One request in flight at a time; the next request is taken while the last result waits.
// Reset clears current time, busy/pending bits, the chain and the controller;
// slot payload (deadline, interval, mode, tag) is not reset.
module periodic_deadline_scheduler_core import pds_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input logic     clk,
	input logic     arst_n,
	pds_req_if.sink   req,
	pds_rsp_if.source rsp
);

	localparam int IW = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [CW-1:0] SCAN_LEN = CW'(SLOT_COUNT);

	// controller state
	state_t        state_q, state_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          sched_q;
	logic [31:0]   now_q;
	logic [7:0]    tag_q;
	logic [23:0]   delay_q, period_q;
	logic [1:0]    kind_q;

	// result register
	logic       out_vld_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_tag_q;
	logic [3:0] out_idx_q;
	logic       out_last_q;

	// cell chain
	pds_cmd_t      cmd;
	logic [IW-1:0] cmd_idx;
	pds_tok_t      tok_in [SLOT_COUNT];
	logic [IW-1:0] tok_in_idx [SLOT_COUNT];
	pds_tok_t      tok [SLOT_COUNT];
	logic [IW-1:0] tok_idx [SLOT_COUNT];
	pds_stat_t     stat [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] busy_vec, pend_vec;

	logic          accept, scan_done, can_emit, emit;
	pds_tok_t      win;
	logic [IW-1:0] win_idx;
	logic [IW+3:0] win_idx_ext;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign tok_in[i]     = '0;
			assign tok_in_idx[i] = '0;
		end else begin : g_link
			assign tok_in[i]     = tok[i-1];
			assign tok_in_idx[i] = tok_idx[i-1];
		end
		pds_cell #(.IW(IW), .IDX(i)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.cmd_idx     (cmd_idx),
			.now         (now_q),
			.tok_in      (tok_in[i]),
			.tok_in_idx  (tok_in_idx[i]),
			.tok_out     (tok[i]),
			.tok_out_idx (tok_idx[i]),
			.stat        (stat[i])
		);
		assign busy_vec[i] = stat[i].busy;
		assign pend_vec[i] = stat[i].pending;
	end

	// The candidate leaving the last cell is the winner once a full pass has
	// elapsed since the last change of slot state.
	assign win         = tok[SLOT_COUNT-1];
	assign win_idx     = tok_idx[SLOT_COUNT-1];
	assign win_idx_ext = {4'b0, win_idx};

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign scan_done = (cnt_q == SCAN_LEN);
	assign can_emit  = !out_vld_q || rsp.ready;
	assign emit      = (state_q == ST_SCAN) && scan_done && can_emit;

	// Broadcast to the cells: age capture, fire update or slot write.
	always_comb begin
		cmd.prep   = (state_q == ST_PREP);
		cmd.fire   = emit && !sched_q && win.vld;
		cmd.wr     = emit && sched_q && win.vld;
		cmd.sched  = sched_q;
		cmd.tag    = tag_q;
		cmd.delay  = delay_q;
		cmd.period = period_q;
		cmd.kind   = kind_q;
		cmd_idx    = win_idx;
	end

	// Next state: a tick keeps scanning until a pass finds nothing due.
	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cnt_n = '0;
				if (accept) begin
					state_n = (req.operation == OP_TICK) ? ST_PREP : ST_SCAN;
				end
			end
			ST_PREP: begin
				state_n = ST_SCAN;
				cnt_n   = '0;
			end
			ST_SCAN: begin
				if (emit) begin
					cnt_n   = '0;
					state_n = (!sched_q && win.vld) ? ST_SCAN : ST_IDLE;
				end else if (!scan_done) begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			default: begin
				state_n = ST_IDLE;
				cnt_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			sched_q   <= 1'b0;
			now_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (accept) begin
				sched_q <= (req.operation == OP_SCHEDULE);
				if (req.operation == OP_TICK) begin
					now_q <= now_q + 32'd1;
				end
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// request payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q    <= req.task_tag;
			delay_q  <= req.first_delay;
			period_q <= req.repeat_interval;
			kind_q   <= req.task_mode;
		end
		if (emit) begin
			if (sched_q) begin
				out_kind_q <= win.vld ? RK_ACCEPT : RK_REJECT;
				out_tag_q  <= tag_q;
				out_idx_q  <= win.vld ? win_idx_ext[3:0] : 4'd0;
				out_last_q <= 1'b1;
			end else if (win.vld) begin
				out_kind_q <= RK_FIRED;
				out_tag_q  <= win.tag;
				out_idx_q  <= win_idx_ext[3:0];
				out_last_q <= 1'b0;
			end else begin
				out_kind_q <= RK_TICKDONE;
				out_tag_q  <= 8'd0;
				out_idx_q  <= 4'd0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.fired_tag   = out_tag_q;
	assign rsp.slot_index  = out_idx_q;
	assign rsp.last_result = out_last_q;

	// A granted slot must have been free.
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !busy_vec[cmd_idx])
		else $error("schedule granted a busy slot");

	// A fired slot must be busy and still pending this tick.
	a_fire_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |-> (busy_vec[cmd_idx] && pend_vec[cmd_idx]))
		else $error("fired a slot that was not pending");

	// After the closing result of a tick nothing is left pending.
	a_tick_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !sched_q && !win.vld) |=> (pend_vec == '0))
		else $error("pending slot left after tick done");

	// Time moves only on an accepted tick.
	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && req.operation == OP_TICK) |=> $stable(now_q))
		else $error("current time changed without a tick");

endmodule
